[rtl/core/tsched_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsched_pkg
// shared types and constants for the multi-policy task scheduler
// ----------------------------------------------------------------------------
package tsched_pkg;
    localparam int TASK_COUNT_DEF    = 32;
    localparam int TIME_BITS_DEF     = 16;
    localparam int PRIORITY_BITS_DEF = 3;
    localparam int SUM_BITS          = 21;
    localparam logic [SUM_BITS-1:0] SUM_MAX = 21'h1FFFFF;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_SRT  = 2'd1;
    localparam logic [1:0] MODE_RR   = 2'd2;
    localparam logic [1:0] MODE_RRP  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;      // write table entry from input item
        logic restart;   // clear table and counters
        logic scan_init; // begin a scan pass
        logic scan_step; // examine one entry
        logic top_done;  // priority pass finished, start pick pass
        logic commit;    // apply the tick
    } tsched_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last; // current entry is the last of the pass
        logic held_ok;   // fcfs held task may continue
    } tsched_sts_t;
endpackage
`default_nettype wire

[rtl/core/task_scheduler_multi_policy.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// task_scheduler_multi_policy
// task table with fcfs, shortest remaining, round robin and priority round robin
// ----------------------------------------------------------------------------
// load and restart items are applied as they are accepted. a tick walks the
// table one entry per cycle: one scan pass, or two in priority round robin mode
// (one pass for the top priority, one for the pick), and no pass when fcfs
// keeps its held task, then a commit state, then an output state that loads the
// output register once the output is not stalled.
module task_scheduler_multi_policy #(
    parameter int TASK_COUNT    = tsched_pkg::TASK_COUNT_DEF,
    parameter int TIME_BITS     = tsched_pkg::TIME_BITS_DEF,
    parameter int PRIORITY_BITS = tsched_pkg::PRIORITY_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [1:0]                 cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 kind,
    input  wire logic [4:0]                 task_index,
    input  wire logic [TIME_BITS-1:0]       arrival_time,
    input  wire logic [TIME_BITS-1:0]       run_length,
    input  wire logic [PRIORITY_BITS-1:0]   task_priority,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            scheduled,
    output logic [4:0]                      run_index,
    output logic [TIME_BITS-1:0]            slot_time,
    output logic                            started_now,
    output logic                            finished_now,
    output logic [TIME_BITS-1:0]            turnaround,
    output logic [tsched_pkg::SUM_BITS-1:0] total_turnaround,
    output logic                            all_done
);
    import tsched_pkg::*;

    logic [1:0]  mode_reg;
    tsched_cmd_t cmd;
    tsched_sts_t sts;
    logic        out_load;
    logic        r_sched, r_start, r_fin, r_done;
    logic [4:0]  r_idx;
    logic [TIME_BITS-1:0] r_slot, r_turn;
    logic [SUM_BITS-1:0]  r_total;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_FCFS;
        else if (cfg_valid && cfg_ready)
            mode_reg <= cfg_data;
    end

    tsched_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .mode(mode_reg), .out_busy(out_valid && out_stall),
        .out_load(out_load), .cmd(cmd), .sts(sts)
    );

    tsched_dp #(
        .TASK_COUNT(TASK_COUNT), .TIME_BITS(TIME_BITS), .PRIORITY_BITS(PRIORITY_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .mode(mode_reg),
        .task_index(task_index), .arrival_time(arrival_time),
        .run_length(run_length), .task_priority(task_priority),
        .r_scheduled(r_sched), .r_run_index(r_idx), .r_slot_time(r_slot),
        .r_started(r_start), .r_finished(r_fin), .r_turnaround(r_turn),
        .r_total(r_total), .r_all_done(r_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (out_load)
            out_valid <= 1'b1;
        else if (!out_stall)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            scheduled        <= r_sched;
            run_index        <= r_idx;
            slot_time        <= r_slot;
            started_now      <= r_start;
            finished_now     <= r_fin;
            turnaround       <= r_turn;
            total_turnaround <= r_total;
            all_done         <= r_done;
        end
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot_time))
        else $error("stalled transfer changed");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !(out_valid && out_stall))
        else $error("result overwritten");
    a_in_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("input valid dropped while stalled");
`endif
endmodule
`default_nettype wire

[rtl/core/tsched_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsched_ctrl
// sequencer: accepts items, runs the entry scans and hands off results
// ----------------------------------------------------------------------------
module tsched_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [1:0]              kind,
    input  wire logic [1:0]              mode,
    input  wire logic                    out_busy,
    output logic                         out_load,
    output tsched_pkg::tsched_cmd_t      cmd,
    input  tsched_pkg::tsched_sts_t      sts
);
    import tsched_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TOP  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_CMT  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_LOAD:    cmd.load = 1'b1;
                        KIND_RESTART: cmd.restart = 1'b1;
                        KIND_TICK:
                        begin
                            cmd.scan_init = 1'b1;
                            state_next = (mode == MODE_RRP) ? ST_TOP : ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_TOP:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.top_done = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (mode == MODE_FCFS && sts.held_ok)
                    state_next = ST_CMT;
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (sts.scan_last)
                        state_next = ST_CMT;
                end
            end
            ST_CMT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    a_commit_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> state_reg == ST_OUT)
        else $error("commit not followed by output");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> state_reg == ST_OUT && !out_busy)
        else $error("result loaded outside output state");
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> in_stall)
        else $error("input open during scan");
`endif
endmodule
`default_nettype wire

[rtl/core/tsched_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tsched_dp
// task table, scan unit for the four policies and tick bookkeeping
// ----------------------------------------------------------------------------
module tsched_dp #(
    parameter int TASK_COUNT    = tsched_pkg::TASK_COUNT_DEF,
    parameter int TIME_BITS     = tsched_pkg::TIME_BITS_DEF,
    parameter int PRIORITY_BITS = tsched_pkg::PRIORITY_BITS_DEF,
    localparam int IW = $clog2(TASK_COUNT)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  tsched_pkg::tsched_cmd_t         cmd,
    output tsched_pkg::tsched_sts_t         sts,
    input  wire logic [1:0]                 mode,
    input  wire logic [4:0]                 task_index,
    input  wire logic [TIME_BITS-1:0]       arrival_time,
    input  wire logic [TIME_BITS-1:0]       run_length,
    input  wire logic [PRIORITY_BITS-1:0]   task_priority,
    output logic                            r_scheduled,
    output logic [4:0]                      r_run_index,
    output logic [TIME_BITS-1:0]            r_slot_time,
    output logic                            r_started,
    output logic                            r_finished,
    output logic [TIME_BITS-1:0]            r_turnaround,
    output logic [tsched_pkg::SUM_BITS-1:0] r_total,
    output logic                            r_all_done
);
    import tsched_pkg::*;

    localparam logic [TIME_BITS-1:0] TMAX = '1;
    localparam logic [IW-1:0] LAST = IW'(TASK_COUNT - 1);

    logic [TIME_BITS-1:0]     arr_mem [TASK_COUNT];
    logic [TIME_BITS-1:0]     rem_mem [TASK_COUNT];
    logic [PRIORITY_BITS-1:0] pri_mem [TASK_COUNT];
    logic [TASK_COUNT-1:0]    fin_reg, started_reg;
    logic [TIME_BITS-1:0]     time_reg;
    logic                     run_v_reg, held_v_reg, rr_v_reg, rrp_v_reg;
    logic [IW-1:0]            run_reg, held_reg, rr_reg, rrp_reg;
    logic [SUM_BITS-1:0]      sum_reg;

    logic [IW-1:0]            cnt_reg, idx;
    logic                     best_v_reg;
    logic [IW-1:0]            best_reg;
    logic [TIME_BITS-1:0]     key_reg;
    logic [PRIORITY_BITS-1:0] top_reg;
    logic                     top_pass_reg;

    logic                     rot_v;
    logic [IW-1:0]            rot_last, start;
    logic                     ready, take;
    logic [TIME_BITS-1:0]     key_i;

    always_comb
    begin
        rot_v    = (mode == MODE_RRP) ? rrp_v_reg : rr_v_reg;
        rot_last = (mode == MODE_RRP) ? rrp_reg : rr_reg;
        start    = !rot_v ? '0 : (rot_last == LAST) ? '0 : rot_last + 1'b1;
        idx      = cnt_reg;
        if ((mode == MODE_RR || mode == MODE_RRP) && !top_pass_reg)
            idx = (({1'b0, start} + {1'b0, cnt_reg}) > (IW+1)'(LAST)) ?
                  IW'({1'b0, start} + {1'b0, cnt_reg} - (IW+1)'(TASK_COUNT)) :
                  start + cnt_reg;
        ready = !fin_reg[idx] && arr_mem[idx] <= time_reg;
        key_i = (mode == MODE_FCFS) ? arr_mem[idx] : rem_mem[idx];
        take  = 1'b0;
        if (ready)
        begin
            case (mode)
                MODE_FCFS, MODE_SRT: take = !best_v_reg || key_i < key_reg;
                MODE_RR:  take = !best_v_reg;
                default:  take = !best_v_reg && pri_mem[idx] == top_reg;
            endcase
        end
        sts.scan_last = (cnt_reg == LAST);
        sts.held_ok   = held_v_reg && run_v_reg && held_reg == run_reg &&
                        !fin_reg[held_reg];
    end

    logic [TIME_BITS-1:0] rem_dec, t_next, turn;
    logic [SUM_BITS:0]    sum_add;
    logic [TASK_COUNT-1:0] fin_after;
    logic                 pick_v;
    logic [IW-1:0]        pick;

    always_comb
    begin
        pick_v  = best_v_reg;
        pick    = best_reg;
        if (mode == MODE_FCFS && sts.held_ok)
        begin
            pick_v = 1'b1;
            pick   = held_reg;
        end
        t_next  = (time_reg < TMAX) ? time_reg + 1'b1 : time_reg;
        rem_dec = (rem_mem[pick] != '0) ? rem_mem[pick] - 1'b1 : '0;
        turn    = t_next - arr_mem[pick];
        sum_add = {1'b0, sum_reg} + (SUM_BITS+1)'(turn);
        fin_after = fin_reg;
        if (pick_v && rem_dec == '0)
            fin_after[pick] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && 32'(task_index) < TASK_COUNT)
        begin
            arr_mem[IW'(task_index)] <= arrival_time;
            rem_mem[IW'(task_index)] <= run_length;
            pri_mem[IW'(task_index)] <= task_priority;
        end
        else if (cmd.commit && pick_v)
            rem_mem[pick] <= rem_dec;
        if (cmd.commit)
        begin
            r_scheduled  <= pick_v;
            r_run_index  <= pick_v ? 5'(pick) : 5'd0;
            r_slot_time  <= time_reg;
            r_started    <= pick_v && !started_reg[pick];
            r_finished   <= pick_v && rem_dec == '0;
            r_turnaround <= (pick_v && rem_dec == '0) ? turn : '0;
            r_total      <= (pick_v && rem_dec == '0) ?
                            ((sum_add > (SUM_BITS+1)'(SUM_MAX)) ? SUM_MAX :
                             sum_add[SUM_BITS-1:0]) : sum_reg;
            r_all_done   <= &fin_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg <= '1; started_reg <= '0; time_reg <= '0; sum_reg <= '0;
            run_v_reg <= 1'b0; held_v_reg <= 1'b0; rr_v_reg <= 1'b0; rrp_v_reg <= 1'b0;
            run_reg <= '0; held_reg <= '0; rr_reg <= '0; rrp_reg <= '0;
            cnt_reg <= '0; best_v_reg <= 1'b0; best_reg <= '0; key_reg <= '0;
            top_reg <= '0; top_pass_reg <= 1'b0;
        end
        else if (cmd.restart)
        begin
            fin_reg <= '1; started_reg <= '0; time_reg <= '0; sum_reg <= '0;
            run_v_reg <= 1'b0; held_v_reg <= 1'b0; rr_v_reg <= 1'b0; rrp_v_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (32'(task_index) < TASK_COUNT)
            begin
                fin_reg[IW'(task_index)]     <= (run_length == '0);
                started_reg[IW'(task_index)] <= 1'b0;
            end
        end
        else if (cmd.scan_init)
        begin
            cnt_reg <= '0; best_v_reg <= 1'b0; top_reg <= '0;
            top_pass_reg <= (mode == MODE_RRP);
        end
        else if (cmd.scan_step)
        begin
            cnt_reg <= sts.scan_last ? '0 : cnt_reg + 1'b1;
            if (top_pass_reg)
            begin
                if (ready && pri_mem[idx] > top_reg)
                    top_reg <= pri_mem[idx];
                if (cmd.top_done)
                    top_pass_reg <= 1'b0;
            end
            else if (take)
            begin
                best_v_reg <= 1'b1;
                best_reg   <= idx;
                key_reg    <= key_i;
            end
        end
        else if (cmd.commit)
        begin
            time_reg <= t_next;
            case (mode)
                MODE_FCFS:
                    if (!sts.held_ok)
                    begin
                        held_v_reg <= best_v_reg;
                        held_reg   <= best_reg;
                    end
                MODE_RR:
                begin
                    rr_v_reg <= best_v_reg;
                    rr_reg   <= best_reg;
                end
                MODE_RRP:
                begin
                    rrp_v_reg <= best_v_reg;
                    rrp_reg   <= best_reg;
                end
                default: ;
            endcase
            if (pick_v)
            begin
                run_v_reg <= 1'b1;
                run_reg   <= pick;
                started_reg[pick] <= 1'b1;
                fin_reg <= fin_after;
                if (rem_dec == '0)
                    sum_reg <= (sum_add > (SUM_BITS+1)'(SUM_MAX)) ? SUM_MAX :
                               sum_add[SUM_BITS-1:0];
            end
        end
    end

`ifndef ASSERT_OFF
    a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> time_reg == $past(t_next))
        else $error("time not advanced by tick");
    a_pick_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && pick_v |-> !fin_reg[pick])
        else $error("finished task picked");
    a_sum_mono: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> sum_reg >= $past(sum_reg))
        else $error("turnaround sum decreased");
`endif
endmodule
`default_nettype wire

[dv/task_scheduler_multi_policy_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_scheduler_multi_policy_tb
// self-checking bench for the multi-policy task scheduler: a behavioral
// scheduler predicts every tick result, which is compared field by field
// against the block output under random idling on both channels
// ----------------------------------------------------------------------------
module task_scheduler_multi_policy_tb;
    import tsched_pkg::*;

    localparam int NTASK      = 32;
    localparam int TMAX       = 65535;
    localparam int DRAIN_WAIT = 100;
    localparam int LIMIT      = 1000000;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct {
        bit        sched;
        bit [4:0]  idx;
        bit [15:0] slot;
        bit        st;
        bit        fin;
        bit [15:0] turn;
        bit [20:0] total;
        bit        done;
    } tick_result_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  kind = 0;
    logic [4:0]  task_index = 0;
    logic [15:0] arrival_time = 0;
    logic [15:0] run_length = 0;
    logic [2:0]  task_priority = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        scheduled;
    logic [4:0]  run_index;
    logic [15:0] slot_time;
    logic        started_now;
    logic        finished_now;
    logic [15:0] turnaround;
    logic [20:0] total_turnaround;
    logic        all_done;

    task_scheduler_multi_policy dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .task_index(task_index), .arrival_time(arrival_time),
        .run_length(run_length), .task_priority(task_priority),
        .out_valid(out_valid), .out_stall(out_stall), .scheduled(scheduled),
        .run_index(run_index), .slot_time(slot_time), .started_now(started_now),
        .finished_now(finished_now), .turnaround(turnaround),
        .total_turnaround(total_turnaround), .all_done(all_done)
    );

    // scheduler state copy
    int         t_arr [NTASK];
    int         t_rem [NTASK];
    int         t_pri [NTASK];
    bit         t_fin [NTASK];
    bit         t_st  [NTASK];
    int         now_t;
    int         running;
    int         fcfs_held;
    int         rr_last;
    int         rrp_last;
    int         turn_sum;
    logic [1:0] policy;

    tick_result_t pending_ticks[$];
    int errors = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int items_sent = 0;

    initial forever #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    function automatic void clear_table();
        for (int i = 0; i < NTASK; i++)
        begin
            t_fin[i] = 1;
            t_st[i]  = 0;
        end
        now_t = 0;
        running = -1;
        fcfs_held = -1;
        rr_last = -1;
        rrp_last = -1;
        turn_sum = 0;
    endfunction

    function automatic bit ready_now(int i);
        return !t_fin[i] && t_arr[i] <= now_t;
    endfunction

    function automatic int rotate_pick(ref int last, input bit use_p, input int p);
        int start;
        int i;
        start = (last < 0) ? 0 : (last + 1) % NTASK;
        for (int k = 0; k < NTASK; k++)
        begin
            i = (start + k) % NTASK;
            if (ready_now(i) && (!use_p || t_pri[i] == p))
            begin
                last = i;
                return i;
            end
        end
        last = -1;
        return -1;
    endfunction

    function automatic int choose_task();
        int best;
        int top;
        best = -1;
        top = 0;
        case (policy)
            MODE_FCFS:
            begin
                if (fcfs_held >= 0 && fcfs_held == running && !t_fin[fcfs_held])
                    return fcfs_held;
                for (int i = 0; i < NTASK; i++)
                    if (ready_now(i) && (best < 0 || t_arr[i] < t_arr[best]))
                        best = i;
                fcfs_held = best;
                return best;
            end
            MODE_SRT:
            begin
                for (int i = 0; i < NTASK; i++)
                    if (ready_now(i) && (best < 0 || t_rem[i] < t_rem[best]))
                        best = i;
                return best;
            end
            MODE_RR:
                return rotate_pick(rr_last, 0, 0);
            default:
            begin
                for (int i = 0; i < NTASK; i++)
                    if (ready_now(i) && t_pri[i] > top)
                        top = t_pri[i];
                return rotate_pick(rrp_last, 1, top);
            end
        endcase
    endfunction

    // apply one accepted item, queue the tick result if there is one
    function automatic void schedule_item(logic [1:0] k, int idx, int a, int l, int p);
        tick_result_t r;
        int pick;
        if (k == KIND_LOAD)
        begin
            t_arr[idx] = a;
            t_rem[idx] = l;
            t_pri[idx] = p;
            t_fin[idx] = (l == 0);
            t_st[idx]  = 0;
            return;
        end
        if (k == KIND_RESTART)
        begin
            clear_table();
            return;
        end
        if (k != KIND_TICK)
            return;
        pick = choose_task();
        r = '{default: 0};
        r.slot = 16'(now_t);
        if (now_t < TMAX)
            now_t++;
        if (pick >= 0)
        begin
            r.sched = 1;
            r.idx = 5'(pick);
            if (!t_st[pick])
            begin
                t_st[pick] = 1;
                r.st = 1;
            end
            running = pick;
            if (t_rem[pick] > 0)
                t_rem[pick]--;
            if (t_rem[pick] == 0)
            begin
                t_fin[pick] = 1;
                r.fin = 1;
                r.turn = 16'(now_t - t_arr[pick]);
                turn_sum += now_t - t_arr[pick];
                if (turn_sum > SUM_MAX)
                    turn_sum = SUM_MAX;
            end
        end
        r.total = 21'(turn_sum);
        r.done = 1;
        for (int i = 0; i < NTASK; i++)
            if (!t_fin[i])
                r.done = 0;
        pending_ticks.push_back(r);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge clk)
    begin
        tick_result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_ticks.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                w = pending_ticks.pop_front();
                if (scheduled !== w.sched) report_mismatch("scheduled", scheduled, w.sched);
                if (run_index !== w.idx) report_mismatch("run_index", run_index, w.idx);
                if (slot_time !== w.slot) report_mismatch("slot_time", slot_time, w.slot);
                if (started_now !== w.st) report_mismatch("started_now", started_now, w.st);
                if (finished_now !== w.fin)
                    report_mismatch("finished_now", finished_now, w.fin);
                if (turnaround !== w.turn) report_mismatch("turnaround", turnaround, w.turn);
                if (total_turnaround !== w.total)
                    report_mismatch("total_turnaround", total_turnaround, w.total);
                if (all_done !== w.done) report_mismatch("all_done", all_done, w.done);
            end
        end
    end

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_item(logic [1:0] k, int idx, int a, int l, int p);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        kind <= k;
        task_index <= 5'(idx);
        arrival_time <= 16'(a);
        run_length <= 16'(l);
        task_priority <= 3'(p);
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        schedule_item(k, idx, a, l, p);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 0;
        while (pending_ticks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic set_policy(logic [1:0] m);
        wait_idle();
        cfg_data <= m;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        policy = m;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic test_config();
        set_policy(MODE_RRP);
        set_policy(MODE_SRT);
        set_policy(MODE_RR);
        set_policy(MODE_FCFS);
    endtask

    task automatic test_directed();
        send_item(KIND_LOAD, 0, 0, 3, 0);
        send_item(KIND_LOAD, 31, 0, 1, 7);
        send_item(KIND_LOAD, 5, 2, 2, 7);
        send_item(KIND_LOAD, 9, 65535, 65535, 5);
        send_item(KIND_LOAD, 12, 1, 0, 3);
        send_item(KIND_NONE, 7, 0, 1, 1);
        send_item(KIND_TICK, 0, 0, 0, 0);
        send_item(KIND_TICK, 0, 0, 0, 0);
        set_policy(MODE_RRP);
        send_item(KIND_TICK, 0, 0, 0, 0);
        send_item(KIND_TICK, 0, 0, 0, 0);
        set_policy(MODE_SRT);
        send_item(KIND_LOAD, 0, 1, 4, 2);
        send_item(KIND_TICK, 0, 0, 0, 0);
        set_policy(MODE_RR);
        send_item(KIND_TICK, 0, 0, 0, 0);
        send_item(KIND_TICK, 0, 0, 0, 0);
        send_item(KIND_TICK, 0, 0, 0, 0);
        set_policy(MODE_FCFS);
        send_item(KIND_TICK, 0, 0, 0, 0);
        send_item(KIND_TICK, 0, 0, 0, 0);
        send_item(KIND_RESTART, 0, 0, 0, 0);
        send_item(KIND_TICK, 0, 0, 0, 0);
        wait_idle();
    endtask

    // one long fcfs task is held tick after tick, then short tasks loaded
    // behind it finish one at a time with large turnarounds
    task automatic test_held_fcfs();
        set_policy(MODE_FCFS);
        send_item(KIND_RESTART, 0, 0, 0, 0);
        send_item(KIND_LOAD, 3, 0, 65535, 1);
        repeat (200) send_item(KIND_TICK, 0, 0, 0, 0);
        for (int i = 0; i < 40; i++)
        begin
            send_item(KIND_LOAD, i % NTASK, 0, 1, i % 8);
            send_item(KIND_TICK, 0, 0, 0, 0);
        end
        send_item(KIND_TICK, 0, 0, 0, 0);
        send_item(KIND_RESTART, 0, 0, 0, 0);
        wait_idle();
    endtask

    task automatic test_random(int quota, bit hold_once);
        int start;
        int a;
        int l;
        int r;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            if ($urandom_range(9) < 2)
                set_policy(2'($urandom_range(3)));
            if ($urandom_range(9) < 8)
                send_item(KIND_RESTART, 0, 0, 0, 0);
            repeat ($urandom_range(1, 8))
            begin
                a = now_t + $urandom_range(0, 6);
                l = $urandom_range(1, 6);
                r = $urandom_range(99);
                if (r < 5) l = 0;
                else if (r < 9) l = $urandom_range(0, 65535);
                if ($urandom_range(99) < 6) a = $urandom_range(0, 65535);
                if (a > TMAX) a = TMAX;
                send_item(KIND_LOAD, $urandom_range(31), a, l, $urandom_range(7));
            end
            repeat ($urandom_range(5, 25))
            begin
                r = $urandom_range(99);
                if (r < 5)
                    send_item(KIND_NONE, $urandom_range(31), $urandom_range(65535),
                              $urandom_range(65535), $urandom_range(7));
                else if (r < 10)
                    send_item(KIND_LOAD, $urandom_range(31), now_t, $urandom_range(1, 4),
                              $urandom_range(7));
                else
                    send_item(KIND_TICK, $urandom_range(31), $urandom_range(65535),
                              $urandom_range(65535), $urandom_range(7));
            end
            if (hold_once && items_sent - start > quota / 2)
            begin
                hold_once = 0;
                in_valid <= 0;
                while (pending_ticks.size() != 0)
                    @(negedge clk);
            end
        end
        wait_idle();
    endtask

    initial
    begin
        policy = MODE_FCFS;
        clear_table();
        repeat (4) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        test_config();
        test_directed();
        send_idle = 8;
        recv_idle = 68;
        test_random(400, 1);
        send_idle = 68;
        recv_idle = 8;
        test_random(400, 0);
        send_idle = 0;
        recv_idle = 0;
        test_random(400, 0);
        test_held_fcfs();
        if (errors == 0 && pending_ticks.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
